// ===== rtl/threshold_rule_matcher_cooldown_macros.svh =====
// ----------------------------------------------------------------------------
// threshold rule matcher assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_RULE_MATCHER_COOLDOWN_MACROS_SVH
`define THRESHOLD_RULE_MATCHER_COOLDOWN_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TRMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TRMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/trmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmc_pkg
// shared types and constants of the threshold rule matcher
// ----------------------------------------------------------------------------
package trmc_pkg;

   localparam int DEF_RULE_SLOTS = 16;
   localparam int MAX_SCAN       = 16;

   // item kinds carried on tuser
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_READING = 1'b1;

   // compare ops of a rule
   localparam logic OP_GT = 1'b0;
   localparam logic OP_LT = 1'b1;

   // one row of the rule table
   typedef struct packed {
      logic [7:0]  sensor;
      logic        op;
      logic [31:0] threshold;
      logic [31:0] cooldown;
      logic [31:0] fire_time;
      logic [31:0] fire_count;
   } trmc_row_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic fetch;
      logic step;
      logic flush;
   } trmc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic fire;
      logic last_rule;
      logic pend_valid;
      logic out_free;
   } trmc_stat_type;

endpackage

// ===== rtl/trmc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmc_ctrl
// sequencer for load, rule scan and final result flush
// ----------------------------------------------------------------------------
module trmc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_kind,
   input  trmc_pkg::trmc_stat_type stat,
   output trmc_pkg::trmc_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } trmc_state_type;

   trmc_state_type state_ff;
   trmc_state_type state_in;
   logic           accept;
   logic           stall;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // a fire needs the pending result moved out first
   assign stall      = stat.fire && stat.pend_valid && !stat.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == trmc_pkg::KIND_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  if (!stat.count_zero) begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (!stall) begin
               cmd.step = 1'b1;
               if (stat.last_rule) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/trmc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmc_dp
// rule table memory, rule evaluation, pending and output registers
// ----------------------------------------------------------------------------
module trmc_dp #(
   parameter int RULE_SLOTS = trmc_pkg::DEF_RULE_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [4:0]             csr_wdata,
   input  logic [3:0]             in_slot,
   input  logic [7:0]             in_sensor_id,
   input  logic [31:0]            in_reading,
   input  logic [31:0]            in_time_ms,
   input  logic                   in_new_op,
   input  logic [31:0]            in_new_threshold,
   input  logic [31:0]            in_new_cooldown,
   input  trmc_pkg::trmc_cmd_type  cmd,
   output trmc_pkg::trmc_stat_type stat,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [3:0]             rsp_rule_index,
   output logic [31:0]            rsp_fire_total,
   output logic                   rsp_tlast
);

   localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam logic [4:0] SCAN_CAP =
      5'((RULE_SLOTS < trmc_pkg::MAX_SCAN) ? RULE_SLOTS : trmc_pkg::MAX_SCAN);

   trmc_pkg::trmc_row_type mem [RULE_SLOTS];
   logic [RULE_SLOTS-1:0]  valid_ff;
   trmc_pkg::trmc_row_type rd_row_ff;
   logic                   rd_valid_ff;

   logic [4:0]  rule_count_ff;
   logic [3:0]  scan_ff;
   logic [3:0]  last_idx_ff;
   logic [7:0]  sensor_ff;
   logic [31:0] value_ff;
   logic [31:0] now_ff;

   logic        pend_valid_ff;
   logic [3:0]  pend_idx_ff;
   logic [31:0] pend_total_ff;

   logic        out_valid_ff;
   logic        out_valid_in;
   logic [3:0]  out_idx_ff;
   logic [31:0] out_total_ff;
   logic        out_last_ff;

   logic [4:0]  scan_len;
   logic [31:0] row_time;
   logic [31:0] row_cnt;
   logic [31:0] new_cnt;
   logic [31:0] elapsed;
   logic        cond_hit;
   logic        cooling;
   logic        fire;
   logic        last_rule;
   logic        out_free;
   logic        slot_ok;
   logic        wr_en;
   logic [IDX_W-1:0] wr_addr;
   trmc_pkg::trmc_row_type wr_row;
   logic        rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic        move_mid;
   logic        move_end;

   // rule evaluation on the row in the read register
   assign scan_len = (rule_count_ff > SCAN_CAP) ? SCAN_CAP : rule_count_ff;
   assign row_time = rd_valid_ff ? rd_row_ff.fire_time  : 32'd0;
   assign row_cnt  = rd_valid_ff ? rd_row_ff.fire_count : 32'd0;
   assign new_cnt  = row_cnt + 32'd1;
   assign elapsed  = now_ff - row_time;
   assign cond_hit = (rd_row_ff.op == trmc_pkg::OP_GT) ?
                     ($signed(value_ff) > $signed(rd_row_ff.threshold)) :
                     ($signed(rd_row_ff.threshold) > $signed(value_ff));
   assign cooling  = (rd_row_ff.cooldown != 32'd0) && (row_time != 32'd0) &&
                     (elapsed < rd_row_ff.cooldown);
   assign fire     = (rd_row_ff.sensor == sensor_ff) && cond_hit && !cooling;
   assign last_rule = (scan_ff == last_idx_ff);
   assign out_free  = !out_valid_ff || rsp_tready;

   assign stat.count_zero = (rule_count_ff == 5'd0);
   assign stat.fire       = fire;
   assign stat.last_rule  = last_rule;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   // single write port: load from idle, writeback during scan
   assign slot_ok = ({28'd0, in_slot} < 32'(RULE_SLOTS));
   assign wr_en   = (cmd.load && slot_ok) || (cmd.step && fire);
   assign wr_addr = cmd.load ? IDX_W'(in_slot) : IDX_W'(scan_ff);

   always_comb begin
      if (cmd.load) begin
         wr_row.sensor     = in_sensor_id;
         wr_row.op         = in_new_op;
         wr_row.threshold  = in_new_threshold;
         wr_row.cooldown   = in_new_cooldown;
         wr_row.fire_time  = 32'd0;
         wr_row.fire_count = 32'd0;
      end else begin
         wr_row            = rd_row_ff;
         wr_row.fire_time  = now_ff;
         wr_row.fire_count = new_cnt;
      end
   end

   assign rd_en   = cmd.fetch || (cmd.step && !last_rule);
   assign rd_addr = cmd.fetch ? '0 : IDX_W'(scan_ff + 4'd1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff   <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // valid bits stand in for the zero reset of trigger time and count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_count_ff <= 5'd0;
      end else if (csr_wen) begin
         rule_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sensor_ff   <= in_sensor_id;
         value_ff    <= in_reading;
         now_ff      <= in_time_ms;
         last_idx_ff <= 4'(scan_len - 5'd1);
      end
      if (cmd.fetch) begin
         scan_ff <= 4'd0;
      end else if (cmd.step && !last_rule) begin
         scan_ff <= scan_ff + 4'd1;
      end
   end

   // a fired rule waits in pend until the scan shows whether it is the last
   assign move_mid = cmd.step && fire && pend_valid_ff;
   assign move_end = cmd.flush && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.step && fire) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && fire) begin
         pend_idx_ff   <= scan_ff;
         pend_total_ff <= new_cnt;
      end
   end

   assign out_valid_in = (move_mid || move_end) ? 1'b1 :
                         (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move_mid || move_end) begin
         out_idx_ff   <= pend_idx_ff;
         out_total_ff <= pend_total_ff;
         out_last_ff  <= move_end;
      end
   end

   assign rsp_tvalid     = out_valid_ff;
   assign rsp_rule_index = out_idx_ff;
   assign rsp_fire_total = out_total_ff;
   assign rsp_tlast      = out_last_ff;

endmodule

// ===== rtl/threshold_rule_matcher_cooldown.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_rule_matcher_cooldown
// matches sensor readings against a table of threshold rules with cooldown
// ----------------------------------------------------------------------------
//  channel   | direction | transaction
//  req_*     | in        | load one rule (tuser 0) or a sensor reading (tuser 1)
//  rsp_*     | out       | one fired rule, tlast on the final one of a reading
//  csr_*     | in        | write of rule_count, taken at once
//
//  a load is taken in idle; a reading passes fetch, a scan of the saturated
//  rule count and a flush (it stays in idle when rule_count is zero), one rule
//  per cycle through the table read port unless a fire stalls the scan
//  reset clears rule_count, all trigger times and counts, and the handshakes
//  a result waits in the output register while the next transaction is
//  accepted; a back-pressured output pauses the scan only when a second fire
//  needs the pending slot, and holds the final flush until the output frees
// ----------------------------------------------------------------------------
module threshold_rule_matcher_cooldown #(
   parameter int RULE_SLOTS = trmc_pkg::DEF_RULE_SLOTS
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,  // slot, sensor_id, reading, time_ms, new_op,
                                     // new_threshold, new_cooldown, zero pad
   input  logic          req_tuser,  // kind
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,  // rule_index, fire_total, zero pad
   output logic          rsp_tlast,
   // configuration
   input  logic          csr_wen,
   input  logic [4:0]    csr_wdata   // rule_count
);

   trmc_pkg::trmc_cmd_type  cmd;
   trmc_pkg::trmc_stat_type stat;

   logic [3:0]  rsp_rule_index;
   logic [31:0] rsp_fire_total;

   // unpack request fields
   logic [3:0]  req_slot;
   logic [7:0]  req_sensor_id;
   logic [31:0] req_reading;
   logic [31:0] req_time_ms;
   logic        req_new_op;
   logic [31:0] req_new_threshold;
   logic [31:0] req_new_cooldown;

   assign req_slot          = req_tdata[3:0];
   assign req_sensor_id     = req_tdata[11:4];
   assign req_reading       = req_tdata[43:12];
   assign req_time_ms       = req_tdata[75:44];
   assign req_new_op        = req_tdata[76];
   assign req_new_threshold = req_tdata[108:77];
   assign req_new_cooldown  = req_tdata[140:109];

   // sequencer
   trmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   // rule table and evaluation
   trmc_dp #(
      .RULE_SLOTS (RULE_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_wdata        (csr_wdata),
      .in_slot          (req_slot),
      .in_sensor_id     (req_sensor_id),
      .in_reading       (req_reading),
      .in_time_ms       (req_time_ms),
      .in_new_op        (req_new_op),
      .in_new_threshold (req_new_threshold),
      .in_new_cooldown  (req_new_cooldown),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_rule_index   (rsp_rule_index),
      .rsp_fire_total   (rsp_fire_total),
      .rsp_tlast        (rsp_tlast)
   );

   // pack response fields, pad to whole bytes
   assign rsp_tdata = {4'd0, rsp_fire_total, rsp_rule_index};

endmodule

// ===== rtl/trmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trmc_checker
// port-level checks of the threshold rule matcher
// ----------------------------------------------------------------------------
`include "threshold_rule_matcher_cooldown_macros.svh"

module trmc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic         rsp_tlast
);

   // no result survives a reset
   `TRMC_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid, "rsp valid after reset")

   // a stalled result holds its payload
   `TRMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")

   // after a rule load the request channel is ready again in the next cycle
   `TRMC_ASSERT_NEXT(a_load_one_cycle, clock, reset, req_tvalid && req_tready && (req_tuser == trmc_pkg::KIND_LOAD), req_tready, "not ready after rule load")

endmodule

bind threshold_rule_matcher_cooldown trmc_checker u_trmc_checker (.*);
